### src/small_matrix_alu_top_macros.svh
// Assertion helpers used by the checker file.
`ifndef SMALL_MATRIX_ALU_TOP_MACROS_SVH
`define SMALL_MATRIX_ALU_TOP_MACROS_SVH

// Checked at every rising edge, reset included.
`define SMA_ASSERT(label, clk_i, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

// Checked only outside reset.
`define SMA_ASSERT_RST(label, clk_i, rst_i, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) prop) else $error(msg);

`endif

### src/sma_pkg.sv
package sma_pkg;

  localparam int MAX_DIM_DEF = 8;

  localparam int VAL_W      = 16;  // stored element
  localparam int TERM_W     = 32;  // one product or sum
  localparam int RES_W      = 35;  // accumulated result
  localparam int IDX_W      = 3;   // row / col fields
  localparam int DIM_W      = 4;   // dimension registers and loop counters
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_WR_A    = 2'd0,
    OP_WR_B    = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    MODE_MUL   = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_SUB   = 2'd2,
    MODE_TRANS = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_ROWS_A = 3'd1,
    CFG_COLS_A = 3'd2,
    CFG_ROWS_B = 3'd3,
    CFG_COLS_B = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_OUT,
    ST_ERR
  } state_t;

  typedef struct packed {
    logic             we_a;
    logic             we_b;
    logic             rd;
    logic [DIM_W-1:0] a_row;
    logic [DIM_W-1:0] a_col;
    logic [DIM_W-1:0] b_row;
    logic [DIM_W-1:0] b_col;
    mode_t            mode;
    logic             mul_en;
    logic             acc_en;
    logic             acc_clr;
    logic             load_out;
    logic [DIM_W-1:0] out_row;
    logic [DIM_W-1:0] out_col;
    logic             last;
    logic             err;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

### src/small_matrix_alu_top.sv
// Small integer matrix unit. Write words (operation 0 for A, 1 for B) store one
// signed 16-bit element each and are taken one per cycle while idle. A compute
// word (operation 2) runs the configured mode and streams the result row-major,
// one word per element, tlast on the final one; a mismatched, zero or too large
// dimension gives a single word with tuser set and all data zero. Each element
// is built from read / multiply / accumulate steps through single-port A and B
// memories and one 16x16 multiplier: multiply repeats the steps for each of the
// cols_a terms, add, subtract and transpose do them once; each element and an
// error word then wait for a free output register. No word is taken while a
// compute is running. Configuration may only be written while the unit is idle.
module small_matrix_alu_top #(
  parameter int MAX_DIM = sma_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // operation, row, col, value
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [47:0]                    m_axis_tdata,  // out_row, out_col, out_value, pad
  output logic                           m_axis_tlast,
  output logic                           m_axis_tuser,  // error
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sma_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sma_pkg::*;

  cmd_t                    cmd;
  stat_t                   stat;
  logic [OP_W-1:0]         in_op;
  logic [IDX_W-1:0]        in_row, in_col;
  logic [VAL_W-1:0]        in_value;
  logic [IDX_W-1:0]        out_row, out_col;
  logic signed [RES_W-1:0] out_value;

  assign in_op     = s_axis_tdata[1:0];
  assign in_row    = s_axis_tdata[4:2];
  assign in_col    = s_axis_tdata[7:5];
  assign in_value  = s_axis_tdata[23:8];
  assign cfg_ready = 1'b1;

  assign m_axis_tdata = {7'd0, out_value, out_col, out_row};

  sma_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .in_op     (in_op),
    .in_row    (in_row),
    .in_col    (in_col),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .cmd       (cmd)
  );

  sma_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_value  (in_value),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (m_axis_tlast),
    .out_err   (m_axis_tuser)
  );

endmodule

### src/sma_ctrl.sv
module sma_ctrl #(
  parameter int MAX_DIM = sma_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_valid,
  output logic                           s_ready,
  input  logic [sma_pkg::OP_W-1:0]       in_op,
  input  logic [sma_pkg::IDX_W-1:0]      in_row,
  input  logic [sma_pkg::IDX_W-1:0]      in_col,
  input  logic                           cfg_valid,
  input  logic [sma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sma_pkg::CFG_DATA_W-1:0] cfg_data,
  input  sma_pkg::stat_t                 stat,
  output sma_pkg::cmd_t                  cmd
);
  import sma_pkg::*;

  localparam logic [DIM_W:0] MAX_DIM_V = (DIM_W+1)'(MAX_DIM);

  state_t           state, state_next;
  mode_t            mode;
  logic [DIM_W-1:0] rows_a, cols_a, rows_b, cols_b;
  logic [DIM_W-1:0] r, c, k, r_next, c_next, k_next;
  logic [DIM_W-1:0] nr, nc, klen;
  logic             dims_ok, in_range, el_last, k_last;

  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    dim_ok = (d != '0) && ({1'b0, d} <= MAX_DIM_V);
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_MUL;
      rows_a <= DIM_W'(1);
      cols_a <= DIM_W'(1);
      rows_b <= DIM_W'(1);
      cols_b <= DIM_W'(1);
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:   mode   <= mode_t'(cfg_data[1:0]);
        CFG_ROWS_A: rows_a <= cfg_data[DIM_W-1:0];
        CFG_COLS_A: cols_a <= cfg_data[DIM_W-1:0];
        CFG_ROWS_B: rows_b <= cfg_data[DIM_W-1:0];
        CFG_COLS_B: cols_b <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // loop bounds and the dimension check for the current mode
  always_comb begin
    case (mode)
      MODE_MUL: begin
        dims_ok = dim_ok(rows_a) && dim_ok(cols_a) && dim_ok(rows_b) &&
                  dim_ok(cols_b) && (cols_a == rows_b);
        nr      = rows_a;
        nc      = cols_b;
        klen    = cols_a;
      end
      MODE_ADD, MODE_SUB: begin
        dims_ok = dim_ok(rows_a) && dim_ok(cols_a) && dim_ok(rows_b) &&
                  dim_ok(cols_b) && (rows_a == rows_b) && (cols_a == cols_b);
        nr      = rows_a;
        nc      = cols_a;
        klen    = DIM_W'(1);
      end
      default: begin
        dims_ok = dim_ok(rows_a) && dim_ok(cols_a);
        nr      = cols_a;
        nc      = rows_a;
        klen    = DIM_W'(1);
      end
    endcase
  end

  assign in_range = ((DIM_W+1)'(in_row) < MAX_DIM_V) && ((DIM_W+1)'(in_col) < MAX_DIM_V);
  assign el_last  = (r == nr - DIM_W'(1)) && (c == nc - DIM_W'(1));
  assign k_last   = (k == klen - DIM_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      r     <= '0;
      c     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      r     <= r_next;
      c     <= c_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next  = state;
    r_next      = r;
    c_next      = c;
    k_next      = k;
    s_ready     = 1'b0;
    cmd         = '0;
    cmd.mode    = mode;
    cmd.out_row = r;
    cmd.out_col = c;
    cmd.last    = el_last;
    cmd.acc_clr = (k == '0);

    case (mode)
      MODE_MUL: begin
        cmd.a_row = r;
        cmd.a_col = k;
        cmd.b_row = k;
        cmd.b_col = c;
      end
      MODE_TRANS: begin
        cmd.a_row = c;
        cmd.a_col = r;
        cmd.b_row = c;
        cmd.b_col = r;
      end
      default: begin
        cmd.a_row = r;
        cmd.a_col = c;
        cmd.b_row = r;
        cmd.b_col = c;
      end
    endcase

    case (state)
      ST_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          case (op_t'(in_op))
            OP_WR_A: cmd.we_a = in_range;
            OP_WR_B: cmd.we_b = in_range;
            OP_COMPUTE: begin
              r_next     = '0;
              c_next     = '0;
              k_next     = '0;
              state_next = dims_ok ? ST_READ : ST_ERR;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_en = 1'b1;
        if (k_last) begin
          state_next = ST_OUT;
        end else begin
          k_next     = k + DIM_W'(1);
          state_next = ST_READ;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          k_next       = '0;
          if (el_last) begin
            state_next = ST_IDLE;
          end else begin
            if (c == nc - DIM_W'(1)) begin
              c_next = '0;
              r_next = r + DIM_W'(1);
            end else begin
              c_next = c + DIM_W'(1);
            end
            state_next = ST_READ;
          end
        end
      end
      ST_ERR: begin
        cmd.err     = 1'b1;
        cmd.last    = 1'b1;
        cmd.out_row = '0;
        cmd.out_col = '0;
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### src/sma_dp.sv
module sma_dp #(
  parameter int MAX_DIM = sma_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [sma_pkg::IDX_W-1:0]        in_row,
  input  logic [sma_pkg::IDX_W-1:0]        in_col,
  input  logic [sma_pkg::VAL_W-1:0]        in_value,
  input  sma_pkg::cmd_t                    cmd,
  output sma_pkg::stat_t                   stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sma_pkg::IDX_W-1:0]        out_row,
  output logic [sma_pkg::IDX_W-1:0]        out_col,
  output logic signed [sma_pkg::RES_W-1:0] out_value,
  output logic                             out_last,
  output logic                             out_err
);
  import sma_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIN_W  = 2 * DIM_W;

  logic [VAL_W-1:0]         mem_a [0:DEPTH-1];
  logic [VAL_W-1:0]         mem_b [0:DEPTH-1];
  logic [ADDR_W-1:0]        wr_addr, a_addr, b_addr;
  logic signed [VAL_W-1:0]  a_q, b_q;
  logic signed [TERM_W-1:0] term, term_next;
  logic signed [RES_W-1:0]  acc, acc_base;

  // row-major element address
  function automatic logic [ADDR_W-1:0] lin(input logic [DIM_W-1:0] rr,
                                            input logic [DIM_W-1:0] cc);
    logic [LIN_W-1:0] t;
    t   = LIN_W'(rr) * LIN_W'(MAX_DIM) + LIN_W'(cc);
    lin = t[ADDR_W-1:0];
  endfunction

  assign wr_addr = lin(DIM_W'(in_row), DIM_W'(in_col));
  assign a_addr  = lin(cmd.a_row, cmd.a_col);
  assign b_addr  = lin(cmd.b_row, cmd.b_col);

  always_ff @(posedge clk) begin
    if (cmd.we_a) mem_a[wr_addr] <= in_value;
    if (cmd.rd)   a_q <= mem_a[a_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.we_b) mem_b[wr_addr] <= in_value;
    if (cmd.rd)   b_q <= mem_b[b_addr];
  end

  always_comb begin
    case (cmd.mode)
      MODE_MUL: term_next = a_q * b_q;
      MODE_ADD: term_next = TERM_W'(a_q) + TERM_W'(b_q);
      MODE_SUB: term_next = TERM_W'(a_q) - TERM_W'(b_q);
      default:  term_next = TERM_W'(a_q);
    endcase
  end

  assign acc_base = cmd.acc_clr ? RES_W'(0) : acc;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) term <= term_next;
    if (cmd.acc_en) acc  <= acc_base + RES_W'(term);
  end

  // output register: holds one word while the next element is computed
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_row   <= cmd.out_row[IDX_W-1:0];
      out_col   <= cmd.out_col[IDX_W-1:0];
      out_value <= cmd.err ? RES_W'(0) : acc;
      out_last  <= cmd.last;
      out_err   <= cmd.err;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

### src/sma_checker.sv
`include "small_matrix_alu_top_macros.svh"

module sma_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [23:0]                    s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [47:0]                    m_axis_tdata,
  input logic                           m_axis_tlast,
  input logic                           m_axis_tuser,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [sma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [sma_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sma_pkg::*;

  `SMA_ASSERT_RST(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "result word changed while stalled")
  `SMA_ASSERT(a_reset_quiet, clk, rst |=> !m_axis_tvalid, "result word valid right after reset")
  `SMA_ASSERT_RST(a_err_word, clk, rst, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 48'd0), "error word not a lone zero word")
  `SMA_ASSERT_RST(a_busy_compute, clk, rst, s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == OP_COMPUTE) |=> !s_axis_tready, "input taken during compute")

endmodule

bind small_matrix_alu_top sma_checker u_sma_checker (.*);
